// ===== rtl/core/ffbp_pkg.sv =====
// Shared types, sizes and helper functions for the first-fit bin packer.
// Used by the controller, the datapath and the top level. No dependencies.
`timescale 1ns / 1ps

package ffbp_pkg;

  // Bin count; must be a power of two, 2 to 1024
  localparam int NUM_BINS = 16;
  localparam int BIN_W    = $clog2(NUM_BINS);
  localparam int NODE_W   = BIN_W + 1;
  localparam int DATA_W   = 16;
  localparam int CHOSEN_W = 4;

  localparam logic [DATA_W-1:0] CAP_RESET = 16'hFFFF;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // latch the item size, start at the root
    logic fetch;     // read the winner of the probed node
    logic check;     // test the winner's room, step down one level
    logic place;     // add the size to the chosen bin
    logic rd_left;   // replay: read the left child winner
    logic rd_right;  // replay: read the right child winner
    logic rwrite;    // replay: write the node winner, move up
    logic emit;      // load the result into the output register
  } ffbp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic nofit;     // root winner is too small
    logic leaf;      // descent reached a bin
    logic rep_top;   // replay is at the root
  } ffbp_sts_t;

  // Room of a bin, held at zero once the used amount reaches capacity
  function automatic logic [DATA_W-1:0] room_of(input logic [DATA_W-1:0] used,
                                                 input logic [DATA_W-1:0] cap);
    return (used >= cap) ? '0 : (cap - used);
  endfunction

  // Leftmost bin below tree node n
  function automatic logic [BIN_W-1:0] leftmost_leaf(input int n);
    int c;
    c = n;
    for (int k = 0; k < BIN_W; k++) begin
      if (c < NUM_BINS) c = c * 2;
    end
    return BIN_W'(c - NUM_BINS);
  endfunction

  // Bin index masked or extended to the result width
  function automatic logic [CHOSEN_W-1:0] to_chosen(input logic [BIN_W-1:0] b);
    logic [BIN_W+CHOSEN_W-1:0] t;
    t = {{CHOSEN_W{1'b0}}, b};
    return t[CHOSEN_W-1:0];
  endfunction

endpackage

// ===== rtl/core/ffbp_if.sv =====
// Channel interfaces for the first-fit bin packer: item, result and config.
// Depends on ffbp_pkg for field widths.
`timescale 1ns / 1ps

interface ffbp_item_if;
  logic                          valid;
  logic                          ready;
  logic [ffbp_pkg::DATA_W-1:0]   item_size;
  modport source (output valid, output item_size, input ready);
  modport sink   (input valid, input item_size, output ready);
endinterface

interface ffbp_res_if;
  logic                          valid;
  logic                          ready;
  logic [ffbp_pkg::CHOSEN_W-1:0] chosen_bin;
  logic [ffbp_pkg::DATA_W-1:0]   room_left;
  logic                          no_fit;
  modport source (output valid, output chosen_bin, output room_left, output no_fit,
                  input ready);
  modport sink   (input valid, input chosen_bin, input room_left, input no_fit,
                  output ready);
endinterface

interface ffbp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ffbp_pkg::DATA_W-1:0]   bin_capacity;
  modport source (output valid, output bin_capacity, input ready);
  modport sink   (input valid, input bin_capacity, output ready);
endinterface

// ===== rtl/core/ffbp_datapath.sv =====
// Datapath of the first-fit bin packer: bin fill registers, winner tree,
// descent and replay registers, result and output registers. Uses ffbp_pkg.
`timescale 1ns / 1ps

module ffbp_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ffbp_pkg::ffbp_cmd_t           cmd,
  output ffbp_pkg::ffbp_sts_t           sts,
  input  logic [ffbp_pkg::DATA_W-1:0]   in_item_size,
  input  logic                          cfg_we,
  input  logic [ffbp_pkg::DATA_W-1:0]   cfg_bin_capacity,
  output logic [ffbp_pkg::CHOSEN_W-1:0] out_chosen_bin,
  output logic [ffbp_pkg::DATA_W-1:0]   out_room_left,
  output logic                          out_no_fit
);

  localparam int NB  = ffbp_pkg::NUM_BINS;
  localparam int BW  = ffbp_pkg::BIN_W;
  localparam int NW  = ffbp_pkg::NODE_W;
  localparam int DW  = ffbp_pkg::DATA_W;
  localparam int CW  = ffbp_pkg::CHOSEN_W;

  logic [DW-1:0] cap_r;
  logic [DW-1:0] used_r [NB];
  logic [BW-1:0] win_r  [NB];   // entry 0 is unused; nodes are 1..NB-1

  logic [DW-1:0] size_r;
  logic [NW-1:0] p_r;           // node under test during descent
  logic [BW-1:0] cand_r;        // winner of the node under test
  logic [BW-1:0] rn_r;          // node being rebuilt during replay
  logic [BW-1:0] lw_r;
  logic [BW-1:0] rw_r;
  logic [DW-1:0] lroom_r;

  logic          res_nofit_r;
  logic [BW-1:0] res_bin_r;
  logic [DW-1:0] res_room_r;

  logic [CW-1:0] out_bin_r;
  logic [DW-1:0] out_room_r;
  logic          out_nofit_r;

  logic [NW-1:0] win_addr_c;
  logic [BW-1:0] win_rd_c;
  logic [BW-1:0] used_addr_c;
  logic [DW-1:0] used_rd_c;
  logic [DW-1:0] room_c;
  logic          fit_c;
  logic [NW-1:0] n_c;

  // Winner read port: a leaf node names its own bin
  always_comb begin
    win_addr_c = p_r;
    if (cmd.rd_left)  win_addr_c = {rn_r, 1'b0};
    if (cmd.rd_right) win_addr_c = {rn_r, 1'b1};
    win_rd_c = win_addr_c[BW] ? win_addr_c[BW-1:0] : win_r[win_addr_c[BW-1:0]];
  end

  // Fill read port and room of the addressed bin
  always_comb begin
    used_addr_c = cand_r;
    if (cmd.place)    used_addr_c = res_bin_r;
    if (cmd.rd_right) used_addr_c = lw_r;
    if (cmd.rwrite)   used_addr_c = rw_r;
    used_rd_c = used_r[used_addr_c];
    room_c    = ffbp_pkg::room_of(used_rd_c, cap_r);
  end

  // Descent step: go left when the left winner fits, else right
  assign fit_c = (room_c >= size_r);
  assign n_c   = fit_c ? p_r : (p_r + NW'(1));

  assign sts.nofit   = (p_r == NW'(1)) && !fit_c;
  assign sts.leaf    = n_c[BW];
  assign sts.rep_top = (rn_r == BW'(1));

  // State, descent, replay and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= ffbp_pkg::CAP_RESET;
      for (int i = 0; i < NB; i++) begin
        used_r[i] <= '0;
        win_r[i]  <= ffbp_pkg::leftmost_leaf(i);
      end
    end else begin
      if (cfg_we) cap_r <= cfg_bin_capacity;

      if (cmd.load) begin
        size_r      <= in_item_size;
        p_r         <= NW'(1);
        res_nofit_r <= 1'b0;
        res_bin_r   <= '0;
        res_room_r  <= '0;
      end

      if (cmd.fetch) cand_r <= win_rd_c;

      if (cmd.check) begin
        p_r <= {n_c[BW-1:0], 1'b0};
        if (sts.nofit) begin
          res_nofit_r <= 1'b1;
        end else if (sts.leaf) begin
          res_bin_r <= n_c[BW-1:0];
        end
      end

      // Place the item and start the replay at the bin's parent
      if (cmd.place) begin
        used_r[res_bin_r] <= used_rd_c + size_r;
        res_room_r        <= room_c - size_r;
        rn_r              <= BW'((NW'(res_bin_r) + NW'(NB)) >> 1);
      end

      if (cmd.rd_left) lw_r <= win_rd_c;

      if (cmd.rd_right) begin
        lroom_r <= room_c;
        rw_r    <= win_rd_c;
      end

      // Rebuild one node, ties to the left, then move up
      if (cmd.rwrite) begin
        win_r[rn_r] <= (lroom_r >= room_c) ? lw_r : rw_r;
        rn_r        <= rn_r >> 1;
      end

      if (cmd.emit) begin
        out_bin_r   <= ffbp_pkg::to_chosen(res_bin_r);
        out_room_r  <= res_room_r;
        out_nofit_r <= res_nofit_r;
      end
    end
  end

  assign out_chosen_bin = out_bin_r;
  assign out_room_left  = out_room_r;
  assign out_no_fit     = out_nofit_r;

  // A new item starts its descent at the root
  a_load_root: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (p_r == NW'(1)))
    else $error("descent did not start at the root");

  // A rejected item is never placed
  a_place_not_nofit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.place |-> !res_nofit_r)
    else $error("placing an item flagged as no fit");

  // Replay never walks past the root
  a_replay_node: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_left || cmd.rd_right || cmd.rwrite) |-> (rn_r != '0))
    else $error("replay node out of range");

endmodule

// ===== rtl/core/ffbp_ctrl.sv =====
// Controller of the first-fit bin packer: sequences descent, placement,
// winner replay and result hand-off. Uses ffbp_pkg command and status types.
`timescale 1ns / 1ps

module ffbp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ffbp_pkg::ffbp_cmd_t  cmd,
  input  ffbp_pkg::ffbp_sts_t  sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_CHECK,
    S_PLACE,
    S_RD_LEFT,
    S_RD_RIGHT,
    S_RWRITE,
    S_EMIT
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Decode the state into datapath commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:     cmd.load     = in_valid;
      S_FETCH:    cmd.fetch    = 1'b1;
      S_CHECK:    cmd.check    = 1'b1;
      S_PLACE:    cmd.place    = 1'b1;
      S_RD_LEFT:  cmd.rd_left  = 1'b1;
      S_RD_RIGHT: cmd.rd_right = 1'b1;
      S_RWRITE:   cmd.rwrite   = 1'b1;
      S_EMIT:     cmd.emit     = !out_valid_r || out_ready;
      default:    cmd          = '0;
    endcase
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit)      out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE:     if (in_valid) state_r <= S_FETCH;
        S_FETCH:    state_r <= S_CHECK;
        S_CHECK: begin
          if (sts.nofit)     state_r <= S_EMIT;
          else if (sts.leaf) state_r <= S_PLACE;
          else               state_r <= S_FETCH;
        end
        S_PLACE:    state_r <= S_RD_LEFT;
        S_RD_LEFT:  state_r <= S_RD_RIGHT;
        S_RD_RIGHT: state_r <= S_RWRITE;
        S_RWRITE: begin
          if (sts.rep_top) state_r <= S_EMIT;
          else             state_r <= S_RD_LEFT;
        end
        S_EMIT:     if (cmd.emit) state_r <= S_IDLE;
        default:    state_r <= S_IDLE;
      endcase
    end
  end

  // A result is loaded only into a free or draining output register
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result overwrites a pending output");

  // Placement always follows a descent step that reached a leaf
  a_place_after_leaf: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.place |-> $past(cmd.check && sts.leaf && !sts.nofit))
    else $error("placement without a completed descent");

  // Finishing the replay at the root leads to the result stage
  a_replay_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rwrite && sts.rep_top) |=> (state_r == S_EMIT))
    else $error("replay did not finish into the result stage");

  // No new item is taken while one is in flight
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_ready)
    else $error("item accepted while busy");

endmodule

// ===== rtl/core/first_fit_bin_packer_unit.sv =====
// Top level of the first-fit bin packer: joins controller and datapath.
// Depends on ffbp_pkg, the channel interfaces, ffbp_ctrl and ffbp_datapath.
//
//   channel  dir  payload                              handshake
//   in_ch    in   item_size[15:0]                      valid/ready
//   out_ch   out  chosen_bin[3:0] room_left[15:0] no_fit  valid/ready
//   cfg_ch   in   bin_capacity[15:0]                   valid/ready, ready tied high
//
// One item at a time. A fitting item takes a fetch and a check per tree level on
// the way down, a place step, a left read, a right read and a write per level to
// rebuild the winners, and an emit step that loads the result. A rejected item
// goes from the root check straight to the emit step. The winner tree and bin
// fill registers have one read port each, which sets the per-level cost. Reset
// restores all bins and the tree. A stalled result stalls only the final stage.
`timescale 1ns / 1ps

module first_fit_bin_packer_unit (
  input  logic       clk,
  input  logic       rst_n,
  ffbp_item_if.sink  in_ch,
  ffbp_res_if.source out_ch,
  ffbp_cfg_if.sink   cfg_ch
);

  ffbp_pkg::ffbp_cmd_t cmd;
  ffbp_pkg::ffbp_sts_t sts;

  // Configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  ffbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ffbp_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_item_size     (in_ch.item_size),
    .cfg_we           (cfg_ch.valid),
    .cfg_bin_capacity (cfg_ch.bin_capacity),
    .out_chosen_bin   (out_ch.chosen_bin),
    .out_room_left    (out_ch.room_left),
    .out_no_fit       (out_ch.no_fit)
  );

endmodule

// ===== test/first_fit_bin_packer_unit_tb.sv =====
// Testbench for first_fit_bin_packer_unit: drives item sizes and capacity writes,
// predicts each bin choice with its own winner tree and checks every result.
// Depends on ffbp_pkg, the channel interfaces in ffbp_if.sv and the RTL top level.
`timescale 1ns / 1ps

module first_fit_bin_packer_unit_tb;

  localparam int NUM_BINS = ffbp_pkg::NUM_BINS;
  localparam int BIN_W    = ffbp_pkg::BIN_W;
  localparam int DATA_W   = ffbp_pkg::DATA_W;
  localparam int CHOSEN_W = ffbp_pkg::CHOSEN_W;

  localparam int QUIET_LIMIT  = 4000;
  localparam int PRINT_LIMIT  = 50;
  localparam int ITEMS_PER_PH = 240;

  typedef enum int {PACE_NONE, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pacing_t;

  typedef struct {
    logic [DATA_W-1:0] size;
    bit                drain;  // hold off until every placement has been checked
  } pending_item_t;

  typedef struct packed {
    logic [CHOSEN_W-1:0] bin;
    logic [DATA_W-1:0]   room;
    logic                no_fit;
  } placement_t;

  logic clk;
  logic rst_n;

  ffbp_item_if in_ch ();
  ffbp_res_if  out_ch ();
  ffbp_cfg_if  cfg_ch ();

  first_fit_bin_packer_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Packer state as predicted
  logic [DATA_W-1:0] cap_q;
  logic [DATA_W-1:0] fill_q [NUM_BINS];
  logic [BIN_W-1:0]  best_q [NUM_BINS];  // entry 0 unused, root at 1

  pending_item_t item_q[$];
  placement_t    placement_q[$];

  int  items_queued;
  int  items_accepted;
  int  mismatches;
  int  quiet_cycles;
  int  send_gap_pct;
  int  recv_stall_pct;
  bit  item_fire;
  bit  cfg_fire;

  function automatic logic [DATA_W-1:0] room_in(input int b);
    return (fill_q[b] >= cap_q) ? '0 : cap_q - fill_q[b];
  endfunction

  // Leaf nodes stand for their own bin, inner nodes for their stored winner
  function automatic int best_below(input int c);
    return (c >= NUM_BINS) ? c - NUM_BINS : int'(best_q[c]);
  endfunction

  // Descend to the first bin that fits, fill it, replay the winners above it
  function automatic placement_t place_item(input logic [DATA_W-1:0] size);
    placement_t r;
    int         n;
    int         b;
    int         lb;
    int         rb;
    r = '0;
    if (room_in(best_below(1)) < size) begin
      r.no_fit = 1'b1;
      return r;
    end
    n = 1;
    while (n < NUM_BINS) begin
      n = (room_in(best_below(2 * n)) >= size) ? 2 * n : 2 * n + 1;
    end
    b      = n - NUM_BINS;
    r.room = room_in(b) - size;
    r.bin  = b[CHOSEN_W-1:0];
    fill_q[b] = fill_q[b] + size;
    for (n = (b + NUM_BINS) >> 1; n >= 1; n = n >> 1) begin
      lb = best_below(2 * n);
      rb = best_below(2 * n + 1);
      best_q[n] = (room_in(lb) >= room_in(rb)) ? BIN_W'(lb) : BIN_W'(rb);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("%0t: %s mismatch: got %0d, expected %0d", $time, field, got, want);
    end
  endtask

  task automatic queue_item(input logic [DATA_W-1:0] size, input bit drain = 1'b0);
    pending_item_t p;
    p.size  = size;
    p.drain = drain;
    item_q.push_back(p);
    items_queued++;
  endtask

  // Block until every queued item is in and every placement has been checked
  task automatic wait_idle();
    while (items_accepted != items_queued || placement_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_capacity(input logic [DATA_W-1:0] c);
    wait_idle();
    @(negedge clk);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.bin_capacity <= c;
    do begin
      @(negedge clk);
    end while (!cfg_fire);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_pacing(input pacing_t mode);
    case (mode)
      PACE_NONE: begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      PACE_SEND_GAPS: begin
        send_gap_pct   = 69;
        recv_stall_pct = 0;
      end
      PACE_RECV_STALLS: begin
        send_gap_pct   = 0;
        recv_stall_pct = 69;
      end
      default: begin
        send_gap_pct   = 31;
        recv_stall_pct = 31;
      end
    endcase
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drive items and result ready at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_ch.valid || item_fire) begin
        if (item_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct &&
            (!item_q[0].drain || placement_q.size() == 0)) begin
          in_ch.valid     <= 1'b1;
          in_ch.item_size <= item_q[0].size;
          void'(item_q.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Sample handshakes at the rising edge: predict, check, track capacity
  always @(posedge clk) begin
    placement_t want;
    item_fire <= rst_n && in_ch.valid && in_ch.ready;
    cfg_fire  <= rst_n && cfg_ch.valid && cfg_ch.ready;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        cap_q = cfg_ch.bin_capacity;
      end
      if (in_ch.valid && in_ch.ready) begin
        placement_q.push_back(place_item(in_ch.item_size));
        items_accepted <= items_accepted + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (placement_q.size() == 0) begin
          report_mismatch("unexpected result", out_ch.chosen_bin, 0);
        end else begin
          want = placement_q.pop_front();
          if (out_ch.chosen_bin !== want.bin)
            report_mismatch("chosen_bin", out_ch.chosen_bin, want.bin);
          if (out_ch.room_left !== want.room)
            report_mismatch("room_left", out_ch.room_left, want.room);
          if (out_ch.no_fit !== want.no_fit)
            report_mismatch("no_fit", out_ch.no_fit, want.no_fit);
        end
      end
      // Count cycles in which nothing moves on any channel
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Watchdog
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Stimulus
  initial begin
    int c;
    int span;
    int lowest;
    int k;
    logic [DATA_W-1:0] size;

    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.item_size     = '0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.bin_capacity = '0;
    items_queued        = 0;
    items_accepted      = 0;
    mismatches          = 0;
    quiet_cycles        = 0;
    item_fire           = 1'b0;
    cfg_fire            = 1'b0;
    set_pacing(PACE_NONE);

    // Predicted state after reset: empty bins, leftmost winners
    cap_q = 16'hFFFF;
    for (int b = 0; b < NUM_BINS; b++) fill_q[b] = '0;
    best_q[0] = '0;
    for (int n = 1; n < NUM_BINS; n++) begin
      c = n;
      while (c < NUM_BINS) c = c * 2;
      best_q[n] = BIN_W'(c - NUM_BINS);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero size, full-range sizes, a bin filled to exactly zero room
    queue_item(16'h0000);
    queue_item(16'hFFFF);
    queue_item(16'h0000);
    queue_item(16'h0001);
    queue_item(16'hFFFF);
    queue_item(16'h5555);
    queue_item(16'hAAAA);
    queue_item(16'hFFFE);

    // Zero capacity: every room clamps to zero, only a zero size fits
    write_capacity(16'h0000);
    queue_item(16'h0000);
    queue_item(16'h0001);
    queue_item(16'hFFFF);

    // Capacity below the amount held in some bins
    write_capacity(16'h0001);
    queue_item(16'h0001);
    queue_item(16'h0001);
    queue_item(16'h0000);
    queue_item(16'h0002);

    // Random phases: capacity set just above the emptiest bin, so bins fill up
    for (int ph = 0; ph < 7; ph++) begin
      set_pacing(pacing_t'(ph % 4));
      span   = $urandom_range(300, 3000);
      lowest = 16'hFFFF;
      foreach (fill_q[b]) begin
        if (fill_q[b] < lowest) lowest = fill_q[b];
      end
      c = lowest + span;
      write_capacity((c > 16'hFFFF) ? 16'hFFFF : DATA_W'(c));
      for (int i = 0; i < ITEMS_PER_PH; i++) begin
        k = $urandom_range(0, 99);
        if (k < 5)       size = '0;
        else if (k < 60) size = DATA_W'($urandom_range(1, span / 8));
        else if (k < 80) size = DATA_W'($urandom_range(span / 8, span));
        else if (k < 90) size = DATA_W'($urandom_range(span, 2 * span));
        else             size = DATA_W'($urandom_range(0, 16'hFFFF));
        queue_item(size, i == ITEMS_PER_PH / 2);
      end
    end

    // Largest capacity: full-range sizes
    set_pacing(PACE_BOTH);
    write_capacity(16'hFFFF);
    for (int i = 0; i < 60; i++) begin
      if ($urandom_range(0, 1) == 0) size = DATA_W'($urandom_range(0, 16'hFFFF));
      else                           size = DATA_W'($urandom_range(0, 4000));
      queue_item(size);
    end

    // Drain, then let the pipeline settle
    wait_idle();
    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== first_fit_bin_packer_unit.f =====
rtl/core/ffbp_pkg.sv
rtl/core/ffbp_if.sv
rtl/core/ffbp_datapath.sv
rtl/core/ffbp_ctrl.sv
rtl/core/first_fit_bin_packer_unit.sv
test/first_fit_bin_packer_unit_tb.sv
